// File: rtl/weekly_schedule_table_macros.svh
// Assertion macros used by the weekly schedule table scan engine.
`ifndef WEEKLY_SCHEDULE_TABLE_MACROS_SVH
`define WEEKLY_SCHEDULE_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define WST_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define WST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/wst_pkg.sv
// Types, constants and day-pattern tables of the weekly schedule table.
`default_nettype none
package wst_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int SEC_W = 20;
   localparam int TOD_W = 17;
   localparam logic [SEC_W-1:0] SECS_WEEK = 20'd604800;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic       en;
      logic       rep;
      logic [3:0] day;
      logic [4:0] sh;
      logic [5:0] sm;
      logic [5:0] ss;
      logic [4:0] eh;
      logic [5:0] em;
      logic [5:0] es;
   } entry_type;

   typedef struct packed {
      logic             mode;
      logic [IDX_W-1:0] index;
      entry_type        entry;
      logic [SEC_W-1:0] now;
   } item_type;

   function automatic logic [2:0] pat_len(input logic [3:0] code);
      logic [2:0] r;
      unique case (code)
         4'd7:                 r = 3'd7;
         4'd8, 4'd12:          r = 3'd5;
         4'd10:                r = 3'd3;
         4'd9, 4'd11, 4'd13:   r = 3'd2;
         4'd14, 4'd15:         r = 3'd0;
         default:              r = 3'd1;
      endcase
      return r;
   endfunction

   function automatic logic [2:0] pat_day(input logic [3:0] code, input logic [2:0] j);
      logic [2:0] r;
      unique case (code)
         4'd7:    r = j;
         4'd8:    r = j + 3'd1;
         4'd9:    r = (j == 3'd0) ? 3'd6 : 3'd0;
         4'd10:   r = {j[1:0], 1'b1};
         4'd11:   r = (j == 3'd0) ? 3'd2 : 3'd4;
         4'd12:   r = j;
         4'd13:   r = (j == 3'd0) ? 3'd5 : 3'd6;
         4'd14, 4'd15: r = 3'd0;
         default: r = code[2:0];
      endcase
      return r;
   endfunction

   function automatic logic [SEC_W-1:0] day_base(input logic [2:0] d);
      logic [SEC_W-1:0] r;
      unique case (d)
         3'd0:    r = 20'd0;
         3'd1:    r = 20'd86400;
         3'd2:    r = 20'd172800;
         3'd3:    r = 20'd259200;
         3'd4:    r = 20'd345600;
         3'd5:    r = 20'd432000;
         3'd6:    r = 20'd518400;
         default: r = 20'd0;
      endcase
      return r;
   endfunction

   function automatic logic [TOD_W-1:0] tod(input logic [4:0] h, input logic [5:0] m,
                                          input logic [5:0] s);
      return TOD_W'(h) * TOD_W'(3600) + TOD_W'(m) * TOD_W'(60) + TOD_W'(s);
   endfunction

   function automatic logic [SEC_W-1:0] wrap_week(input logic [SEC_W-1:0] v);
      return (v >= SECS_WEEK) ? v - SECS_WEEK : v;
   endfunction

endpackage
`default_nettype wire

// File: rtl/wst_front.sv
// Front end: accepts request transfers, packs and normalizes them for the queue.
`default_nettype none
module wst_front (
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_mode,
   input  wire logic [wst_pkg::IDX_W-1:0]     req_entry_index,
   input  wire logic                          req_entry_enable,
   input  wire logic                          req_entry_repeat,
   input  wire logic [3:0]                    req_day_code,
   input  wire logic [4:0]                    req_start_hour,
   input  wire logic [5:0]                    req_start_minute,
   input  wire logic [5:0]                    req_start_sec,
   input  wire logic [4:0]                    req_end_hour,
   input  wire logic [5:0]                    req_end_minute,
   input  wire logic [5:0]                    req_end_sec,
   input  wire logic [wst_pkg::SEC_W-1:0]     req_now_seconds,
   output logic                               push_valid,
   input  wire logic                          push_ready,
   output wst_pkg::item_type                  push_item
);
   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   always_comb begin
      push_item.mode        = req_mode;
      push_item.index       = req_entry_index;
      push_item.entry.en    = req_entry_enable;
      push_item.entry.rep   = req_entry_repeat;
      push_item.entry.day   = req_day_code;
      push_item.entry.sh    = req_start_hour;
      push_item.entry.sm    = req_start_minute;
      push_item.entry.ss    = req_start_sec;
      push_item.entry.eh    = req_end_hour;
      push_item.entry.em    = req_end_minute;
      push_item.entry.es    = req_end_sec;
      push_item.now         = (req_mode == wst_pkg::MODE_QUERY) ?
                              wst_pkg::wrap_week(req_now_seconds) : '0;
   end
endmodule
`default_nettype wire

// File: rtl/wst_fifo.sv
// Two-entry queue between the front end and the scan engine.
`default_nettype none
module wst_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_valid,
   output logic                   push_ready,
   input  wire wst_pkg::item_type push_item,
   output logic                   pop_valid,
   input  wire logic              pop_ready,
   output wst_pkg::item_type      pop_item
);
   wst_pkg::item_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end
endmodule
`default_nettype wire

// File: rtl/wst_scan.sv
// Scan engine: holds the entry table, executes writes and scans it for queries.
`default_nettype none
`include "weekly_schedule_table_macros.svh"
module wst_scan (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [wst_pkg::CNT_W-1:0] entry_count,
   input  wire logic                      pop_valid,
   output logic                           pop_ready,
   input  wire wst_pkg::item_type         pop_item,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output logic                           rsp_next_found,
   output logic [wst_pkg::IDX_W-1:0]      rsp_next_entry,
   output logic [2:0]                     rsp_next_occurrence,
   output logic [wst_pkg::SEC_W-1:0]      rsp_next_start,
   output logic [wst_pkg::SEC_W-1:0]      rsp_next_wait,
   output logic                           rsp_active_found,
   output logic [wst_pkg::IDX_W-1:0]      rsp_active_entry,
   output logic [wst_pkg::SEC_W-1:0]      rsp_active_start,
   output logic [wst_pkg::SEC_W-1:0]      rsp_active_end
);
   localparam int SW = wst_pkg::SEC_W;
   localparam int IW = wst_pkg::IDX_W;
   localparam int CW = wst_pkg::CNT_W;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_READ = 6'b000010,
      S_LOAD = 6'b000100,
      S_OCC  = 6'b001000,
      S_EVAL = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   wst_pkg::entry_type table_mem [wst_pkg::MAX_ENTRIES];
   wst_pkg::entry_type rd_data_ff;

   state_type state_ff, state_in;
   logic [CW-1:0] i_ff, i_in;
   logic [2:0] occ_ff, occ_in;
   logic [SW-1:0] now_ff, now_in;
   wst_pkg::entry_type cur_ff, cur_in;
   logic [wst_pkg::TOD_W-1:0] tods_ff, tods_in, tode_ff, tode_in;
   logic [SW-1:0] st_ff, st_in, en_ff, en_in;
   logic [SW-1:0] best_ff, best_in, ns_ff, ns_in;
   logic nf_ff, nf_in, af_ff, af_in;
   logic [IW-1:0] ne_ff, ne_in, ae_ff, ae_in;
   logic [2:0] no_ff, no_in;
   logic [SW-1:0] as_ff, as_in, aend_ff, aend_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0] n_lim;
   logic [2:0] len;
   logic [2:0] dnum;
   logic [SW-1:0] ahead;
   logic load_out;
   logic do_write;

   assign n_lim = (entry_count > CW'(wst_pkg::MAX_ENTRIES)) ?
                  CW'(wst_pkg::MAX_ENTRIES) : entry_count;
   assign len   = wst_pkg::pat_len(cur_ff.day);
   assign dnum  = wst_pkg::pat_day(cur_ff.day, occ_ff);
   assign ahead = (now_ff < st_ff) ? st_ff - now_ff : wst_pkg::SECS_WEEK - now_ff + st_ff;
   assign pop_ready = (state_ff == S_IDLE);
   assign do_write  = pop_valid && pop_ready && (pop_item.mode == wst_pkg::MODE_WRITE);
   assign load_out  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      i_in = i_ff;
      occ_in = occ_ff;
      now_in = now_ff;
      cur_in = cur_ff;
      tods_in = tods_ff;
      tode_in = tode_ff;
      st_in = st_ff;
      en_in = en_ff;
      best_in = best_ff;
      ns_in = ns_ff;
      nf_in = nf_ff;
      ne_in = ne_ff;
      no_in = no_ff;
      af_in = af_ff;
      ae_in = ae_ff;
      as_in = as_ff;
      aend_in = aend_ff;
      rsp_valid_in = (rsp_valid_ff && !rsp_ready) || load_out;
      unique case (state_ff)
         S_IDLE: begin
            if (pop_valid && pop_item.mode == wst_pkg::MODE_QUERY) begin
               now_in  = pop_item.now;
               i_in    = '0;
               best_in = wst_pkg::SECS_WEEK;
               nf_in = 1'b0; ne_in = '0; no_in = '0; ns_in = '0;
               af_in = 1'b0; ae_in = '0; as_in = '0; aend_in = '0;
               state_in = (n_lim == '0) ? S_DONE : S_READ;
            end
         end
         S_READ: state_in = S_LOAD;
         S_LOAD: begin
            cur_in  = rd_data_ff;
            tods_in = wst_pkg::tod(rd_data_ff.sh, rd_data_ff.sm, rd_data_ff.ss);
            tode_in = wst_pkg::tod(rd_data_ff.eh, rd_data_ff.em, rd_data_ff.es);
            occ_in  = '0;
            if (rd_data_ff.en && wst_pkg::pat_len(rd_data_ff.day) != 3'd0) begin
               state_in = S_OCC;
            end else begin
               i_in = i_ff + CW'(1);
               state_in = (i_ff + CW'(1) == n_lim) ? S_DONE : S_READ;
            end
         end
         S_OCC: begin
            st_in = wst_pkg::wrap_week(SW'(tods_ff) + wst_pkg::day_base(dnum));
            en_in = wst_pkg::wrap_week(SW'(tode_ff) + wst_pkg::day_base(dnum));
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (ahead < best_ff) begin
               best_in = ahead;
               nf_in = 1'b1;
               ne_in = i_ff[IW-1:0];
               no_in = occ_ff;
               ns_in = st_ff;
            end
            if (cur_ff.rep && now_ff >= st_ff && now_ff < en_ff) begin
               af_in = 1'b1;
               ae_in = i_ff[IW-1:0];
               as_in = st_ff;
               aend_in = en_ff;
            end
            if (occ_ff + 3'd1 == len) begin
               i_in = i_ff + CW'(1);
               state_in = (i_ff + CW'(1) == n_lim) ? S_DONE : S_READ;
            end else begin
               occ_in = occ_ff + 3'd1;
               state_in = S_OCC;
            end
         end
         S_DONE: begin
            if (load_out) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         table_mem[pop_item.index] <= pop_item.entry;
      end
      rd_data_ff <= table_mem[i_ff[IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff <= i_in;
      occ_ff <= occ_in;
      now_ff <= now_in;
      cur_ff <= cur_in;
      tods_ff <= tods_in;
      tode_ff <= tode_in;
      st_ff <= st_in;
      en_ff <= en_in;
      best_ff <= best_in;
      ns_ff <= ns_in;
      nf_ff <= nf_in;
      ne_ff <= ne_in;
      no_ff <= no_in;
      af_ff <= af_in;
      ae_ff <= ae_in;
      as_ff <= as_in;
      aend_ff <= aend_in;
      if (load_out) begin
         rsp_next_found      <= nf_ff;
         rsp_next_entry      <= ne_ff;
         rsp_next_occurrence <= no_ff;
         rsp_next_start      <= ns_ff;
         rsp_next_wait       <= nf_ff ? best_ff : '0;
         rsp_active_found    <= af_ff;
         rsp_active_entry    <= ae_ff;
         rsp_active_start    <= as_ff;
         rsp_active_end      <= aend_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `WST_ASSERT_NEXT(a_found_wait, clock, reset, load_out && nf_ff,
      rsp_next_wait != '0 && rsp_next_wait <= wst_pkg::SECS_WEEK, "next wait out of range")
   `WST_ASSERT_NEXT(a_active_order, clock, reset, load_out && af_ff,
      rsp_active_start < rsp_active_end, "active window inverted")
   `WST_ASSERT_NOW(a_occ_bound, clock, reset, state_ff == S_EVAL || state_ff == S_OCC,
      occ_ff < len && i_ff < n_lim, "scan position past pattern or table")
endmodule
`default_nettype wire

// File: rtl/weekly_schedule_table.sv
// Top level of the weekly schedule table: register, front end, queue and scan engine.
// Usage:
//   req_* carries write and query transfers (valid/ready). A write (mode 0) stores one
//   table entry and returns nothing; a query (mode 1) returns one rsp_* transfer with the
//   next start and the active window at req_now_seconds.
//   csr_* writes entry_count; write it only while no query is outstanding.
//   Requests enter a two-entry queue, so the front accepts up to two transfers while the
//   scan engine is busy. The engine executes one item at a time.
//   A query reads the scanned entries one at a time through the single table read port
//   and computes and compares the start of each occurrence of the enabled entries, for up
//   to 64 entries of seven days each. The result sits in an output register.
//   If rsp_ready stays low the finished result holds there, the next query finishes its
//   scan and waits, and the queue then fills and drops req_ready.
//   Reset clears entry_count, the queue and the engine; table contents stay undefined
//   until written, and entries below entry_count must be written before a query.
`default_nettype none
module weekly_schedule_table (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_mode,
   input  wire logic [wst_pkg::IDX_W-1:0]     req_entry_index,
   input  wire logic                          req_entry_enable,
   input  wire logic                          req_entry_repeat,
   input  wire logic [3:0]                    req_day_code,
   input  wire logic [4:0]                    req_start_hour,
   input  wire logic [5:0]                    req_start_minute,
   input  wire logic [5:0]                    req_start_sec,
   input  wire logic [4:0]                    req_end_hour,
   input  wire logic [5:0]                    req_end_minute,
   input  wire logic [5:0]                    req_end_sec,
   input  wire logic [wst_pkg::SEC_W-1:0]     req_now_seconds,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_next_found,
   output logic [wst_pkg::IDX_W-1:0]          rsp_next_entry,
   output logic [2:0]                         rsp_next_occurrence,
   output logic [wst_pkg::SEC_W-1:0]          rsp_next_start,
   output logic [wst_pkg::SEC_W-1:0]          rsp_next_wait,
   output logic                               rsp_active_found,
   output logic [wst_pkg::IDX_W-1:0]          rsp_active_entry,
   output logic [wst_pkg::SEC_W-1:0]          rsp_active_start,
   output logic [wst_pkg::SEC_W-1:0]          rsp_active_end,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [6:0]                    csr_entry_count
);
   logic [wst_pkg::CNT_W-1:0] count_ff, count_in;
   logic push_valid, push_ready, pop_valid, pop_ready;
   wst_pkg::item_type push_item, pop_item;

   assign csr_ready = 1'b1;
   assign count_in  = (csr_valid && csr_ready) ? wst_pkg::CNT_W'(csr_entry_count) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   wst_front u_front (
      .req_valid, .req_ready, .req_mode, .req_entry_index, .req_entry_enable,
      .req_entry_repeat, .req_day_code, .req_start_hour, .req_start_minute,
      .req_start_sec, .req_end_hour, .req_end_minute, .req_end_sec, .req_now_seconds,
      .push_valid, .push_ready, .push_item
   );

   wst_fifo u_fifo (
      .clock, .reset, .push_valid, .push_ready, .push_item,
      .pop_valid, .pop_ready, .pop_item
   );

   wst_scan u_scan (
      .clock, .reset, .entry_count(count_ff), .pop_valid, .pop_ready, .pop_item,
      .rsp_valid, .rsp_ready, .rsp_next_found, .rsp_next_entry, .rsp_next_occurrence,
      .rsp_next_start, .rsp_next_wait, .rsp_active_found, .rsp_active_entry,
      .rsp_active_start, .rsp_active_end
   );
endmodule
`default_nettype wire
